// ----- hw/rtl/ttqbw_pkg.sv -----
package ttqbw_pkg;

   // register map, index = byte address / 4
   localparam int unsigned CSR_ADDR_BITS = 5;
   localparam logic [2:0] REG_TAP_DEBOUNCE     = 3'd0;
   localparam logic [2:0] REG_RELEASE_DEBOUNCE = 3'd1;
   localparam logic [2:0] REG_FAILURE_THRESH   = 3'd2;
   localparam logic [2:0] REG_RECOVERY_COOL    = 3'd3;
   localparam logic [2:0] REG_RECOVERY_BACKOFF = 3'd4;

   // reset values of the configuration registers
   localparam logic [15:0] TAP_DEBOUNCE_RST     = 16'd200;
   localparam logic [15:0] RELEASE_DEBOUNCE_RST = 16'd100;
   localparam logic [7:0]  FAILURE_THRESH_RST   = 8'd3;
   localparam logic [15:0] RECOVERY_COOL_RST    = 16'd1000;
   localparam logic [15:0] RECOVERY_BACKOFF_RST = 16'd50;

   // decode constants
   localparam logic [7:0] NIBBLE_MASK = 8'h0F;
   localparam logic [7:0] MAX_POINTS  = 8'd4;
   localparam logic [7:0] STREAK_MAX  = 8'd255;

   // stream widths
   localparam int unsigned REQ_DATA_BITS = 104;
   localparam int unsigned RSP_DATA_BITS = 136;

   typedef struct packed {
      logic [15:0] tap_debounce_ms;
      logic [15:0] release_debounce_ms;
      logic [7:0]  failure_threshold;
      logic [15:0] recovery_cooldown_ms;
      logic [15:0] recovery_backoff_ms;
   } cfg_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        bus_ok;
      logic [31:0] elapsed_us;
      logic [7:0]  point_count;
      logic [7:0]  x_high_byte;
      logic [7:0]  x_low_byte;
      logic [7:0]  y_high_byte;
      logic [7:0]  y_low_byte;
   } req_type;

   typedef struct packed {
      logic        tap;
      logic [11:0] x_coord;
      logic [11:0] y_coord;
      logic        poll_skipped;
      logic        recover_request;
      logic        finger_down;
      logic [7:0]  failure_streak;
      logic [31:0] stall_total;
      logic [31:0] recovery_total;
      logic [31:0] max_elapsed_us;
   } rsp_type;

endpackage

// ----- hw/rtl/ttqbw_csr.sv -----
module ttqbw_csr
   import ttqbw_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[CSR_ADDR_BITS-1:2];
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_TAP_DEBOUNCE:     cfg_in.tap_debounce_ms      = csr_pwdata[15:0];
            REG_RELEASE_DEBOUNCE: cfg_in.release_debounce_ms  = csr_pwdata[15:0];
            REG_FAILURE_THRESH:   cfg_in.failure_threshold    = csr_pwdata[7:0];
            REG_RECOVERY_COOL:    cfg_in.recovery_cooldown_ms = csr_pwdata[15:0];
            REG_RECOVERY_BACKOFF: cfg_in.recovery_backoff_ms  = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tap_debounce_ms      <= TAP_DEBOUNCE_RST;
         cfg_ff.release_debounce_ms  <= RELEASE_DEBOUNCE_RST;
         cfg_ff.failure_threshold    <= FAILURE_THRESH_RST;
         cfg_ff.recovery_cooldown_ms <= RECOVERY_COOL_RST;
         cfg_ff.recovery_backoff_ms  <= RECOVERY_BACKOFF_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         REG_TAP_DEBOUNCE:     csr_prdata = {16'd0, cfg_ff.tap_debounce_ms};
         REG_RELEASE_DEBOUNCE: csr_prdata = {16'd0, cfg_ff.release_debounce_ms};
         REG_FAILURE_THRESH:   csr_prdata = {24'd0, cfg_ff.failure_threshold};
         REG_RECOVERY_COOL:    csr_prdata = {16'd0, cfg_ff.recovery_cooldown_ms};
         REG_RECOVERY_BACKOFF: csr_prdata = {16'd0, cfg_ff.recovery_backoff_ms};
         default:              csr_prdata = 32'd0;
      endcase
   end

endmodule

// ----- hw/rtl/ttqbw_core.sv -----
module ttqbw_core
   import ttqbw_pkg::*;
#(
   parameter int unsigned TIME_BITS = 32
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   logic                 touch_active_ff, touch_active_in;
   logic [TIME_BITS-1:0] last_tap_ff, last_tap_in;
   logic [TIME_BITS-1:0] last_release_ff, last_release_in;
   logic [7:0]           fail_streak_ff, fail_streak_in;
   logic [TIME_BITS-1:0] poll_allowed_ff, poll_allowed_in;
   logic [TIME_BITS-1:0] last_recovery_ff, last_recovery_in;
   logic [31:0]          recovery_count_ff, recovery_count_in;
   logic [31:0]          stall_count_ff, stall_count_in;
   logic [31:0]          max_duration_ff, max_duration_in;

   logic [TIME_BITS-1:0] now;
   logic [TIME_BITS-1:0] diff_allowed, diff_recovery, diff_tap, diff_release;
   logic                 skip, cooled, tap_ready, release_ready, touched;
   logic [31:0]          max_next;
   logic [7:0]           streak_next;

   // wrapped time differences
   assign now           = TIME_BITS'(item.now_ms);
   assign diff_allowed  = now - poll_allowed_ff;
   assign diff_recovery = now - last_recovery_ff;
   assign diff_tap      = now - last_tap_ff;
   assign diff_release  = now - last_release_ff;

   assign skip          = diff_allowed[TIME_BITS-1];
   assign cooled        = (recovery_count_ff == 32'd0) ||
                          (diff_recovery >= TIME_BITS'(cfg.recovery_cooldown_ms));
   assign tap_ready     = !diff_tap[TIME_BITS-1] &&
                          (diff_tap >= TIME_BITS'(cfg.tap_debounce_ms));
   assign release_ready = !diff_release[TIME_BITS-1] &&
                          (diff_release >= TIME_BITS'(cfg.release_debounce_ms));
   assign touched       = (item.point_count != 8'd0) && (item.point_count <= MAX_POINTS);
   assign max_next      = (item.elapsed_us > max_duration_ff) ? item.elapsed_us
                                                              : max_duration_ff;
   assign streak_next   = (fail_streak_ff == STREAK_MAX) ? fail_streak_ff
                                                         : fail_streak_ff + 8'd1;

   // per-poll state update and result
   always_comb begin
      touch_active_in   = touch_active_ff;
      last_tap_in       = last_tap_ff;
      last_release_in   = last_release_ff;
      fail_streak_in    = fail_streak_ff;
      poll_allowed_in   = poll_allowed_ff;
      last_recovery_in  = last_recovery_ff;
      recovery_count_in = recovery_count_ff;
      stall_count_in    = stall_count_ff;
      max_duration_in   = max_duration_ff;
      result            = '0;

      if (skip) begin
         result.poll_skipped = 1'b1;
         if (touch_active_ff) begin
            last_release_in = now;
            touch_active_in = 1'b0;
         end
      end else if (!item.bus_ok) begin
         max_duration_in = max_next;
         stall_count_in  = stall_count_ff + 32'd1;
         fail_streak_in  = streak_next;
         if (touch_active_ff) begin
            last_release_in = now;
            touch_active_in = 1'b0;
         end
         if ((streak_next >= cfg.failure_threshold) && cooled) begin
            result.recover_request = 1'b1;
            recovery_count_in      = recovery_count_ff + 32'd1;
            last_recovery_in       = now;
            poll_allowed_in        = now + TIME_BITS'(cfg.recovery_backoff_ms);
            fail_streak_in         = 8'd0;
         end
      end else begin
         max_duration_in = max_next;
         fail_streak_in  = 8'd0;
         if (!touched) begin
            if (touch_active_ff) begin
               last_release_in = now;
               touch_active_in = 1'b0;
            end
         end else begin
            result.x_coord = {4'((item.x_high_byte & NIBBLE_MASK)), item.x_low_byte};
            result.y_coord = {4'((item.y_high_byte & NIBBLE_MASK)), item.y_low_byte};
            if (tap_ready && !touch_active_ff && release_ready) begin
               result.tap  = 1'b1;
               last_tap_in = now;
            end
            touch_active_in = 1'b1;
         end
      end

      result.finger_down    = touch_active_in;
      result.failure_streak = fail_streak_in;
      result.stall_total    = stall_count_in;
      result.recovery_total = recovery_count_in;
      result.max_elapsed_us = max_duration_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         touch_active_ff   <= 1'b0;
         last_tap_ff       <= '0;
         last_release_ff   <= '0;
         fail_streak_ff    <= 8'd0;
         poll_allowed_ff   <= '0;
         last_recovery_ff  <= '0;
         recovery_count_ff <= 32'd0;
         stall_count_ff    <= 32'd0;
         max_duration_ff   <= 32'd0;
      end else if (step) begin
         touch_active_ff   <= touch_active_in;
         last_tap_ff       <= last_tap_in;
         last_release_ff   <= last_release_in;
         fail_streak_ff    <= fail_streak_in;
         poll_allowed_ff   <= poll_allowed_in;
         last_recovery_ff  <= last_recovery_in;
         recovery_count_ff <= recovery_count_in;
         stall_count_ff    <= stall_count_in;
         max_duration_ff   <= max_duration_in;
      end
   end

endmodule

// ----- hw/rtl/touch_tap_qualifier_bus_watchdog.sv -----
// Touch tap qualifier with bus watchdog.
// req_ channel: one touch-controller poll per beat. rsp_ channel: one result
// beat per poll, in order. csr_ port: APB-style access to the five debounce,
// threshold, cooldown and backoff registers at byte addresses 0x0 to 0x10.
// A poll accepted into the input register is loaded into the result register
// once the result register is empty or its beat is being taken; rsp_tvalid
// is high while the result register holds a beat.
// Throughput: one poll per cycle while rsp_tready does not stall; each poll
// is handled by a single pass of compare and counter logic between the input
// register and the result register, with the watchdog and touch state updated
// in the same cycle. When the receiver stalls, the result register holds its
// beat and the input register still takes one more poll; after that
// req_tready drops until rsp_tready returns.
// Reset clears all counters, timestamps and the touch flag to zero, loads the
// registers with their default values and empties both pipeline registers;
// req_tready is low while reset is high. Configuration must be written only
// while no poll is in flight, by the user; the block does not enforce it.
module touch_tap_qualifier_bus_watchdog
   import ttqbw_pkg::*;
#(
   parameter int unsigned TIME_BITS = 32
)
(
   input  logic                     clock,
   input  logic                     reset,
   // now_ms[31:0], elapsed_us[63:32], point_count[71:64], x_high_byte[79:72],
   // x_low_byte[87:80], y_high_byte[95:88], y_low_byte[103:96]
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // bus_ok[0]
   input  logic                     req_tuser,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // tap[0], x_coord[12:1], y_coord[24:13], poll_skipped[25], recover_request[26],
   // finger_down[27], failure_streak[35:28], stall_total[67:36],
   // recovery_total[99:68], max_elapsed_us[131:100], zero fill [135:132]
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   cfg_type cfg;
   req_type req_item;
   req_type in_item_ff;
   logic    in_valid_ff, in_valid_in;
   rsp_type core_result;
   rsp_type out_item_ff;
   logic    out_valid_ff, out_valid_in;
   logic    advance;
   logic    req_take;

   // unpack the input beat
   assign req_item.now_ms      = req_tdata[31:0];
   assign req_item.bus_ok      = req_tuser;
   assign req_item.elapsed_us  = req_tdata[63:32];
   assign req_item.point_count = req_tdata[71:64];
   assign req_item.x_high_byte = req_tdata[79:72];
   assign req_item.x_low_byte  = req_tdata[87:80];
   assign req_item.y_high_byte = req_tdata[95:88];
   assign req_item.y_low_byte  = req_tdata[103:96];

   // pipeline handshake
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !reset && (!in_valid_ff || advance);
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   ttqbw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ttqbw_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= core_result;
      end
   end

   // pack the result beat
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0,
                        out_item_ff.max_elapsed_us,
                        out_item_ff.recovery_total,
                        out_item_ff.stall_total,
                        out_item_ff.failure_streak,
                        out_item_ff.finger_down,
                        out_item_ff.recover_request,
                        out_item_ff.poll_skipped,
                        out_item_ff.y_coord,
                        out_item_ff.x_coord,
                        out_item_ff.tap};

   // a recovery request always restarts the failure streak
   a_recover_clears_streak: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_item_ff.recover_request |-> out_item_ff.failure_streak == 8'd0)
      else $error("recovery result with non-zero failure streak");

   // a skipped poll carries no tap, no recovery and no coordinates
   a_skip_is_quiet: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_item_ff.poll_skipped |->
         !out_item_ff.tap && !out_item_ff.recover_request &&
         out_item_ff.x_coord == 12'd0 && out_item_ff.y_coord == 12'd0 &&
         !out_item_ff.finger_down)
      else $error("skipped poll produced activity");

   // a tap leaves the finger down
   a_tap_finger_down: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_item_ff.tap |-> out_item_ff.finger_down)
      else $error("tap reported without finger down");

   // input side is only held off when both stages are full and stalled
   a_backpressure_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && out_valid_ff && !rsp_tready)
      else $error("input stalled with room in the pipeline");

   // a stalled result beat is not overwritten
   a_stall_holds_result: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |=> out_valid_ff && $stable(out_item_ff))
      else $error("result register changed under stall");

endmodule
